// ===== design/vdi_pkg.sv =====
package vdi_pkg;

  localparam int POS_W            = 24;
  localparam int COL_W            = 16;
  localparam int TOL_W            = 16;
  localparam int IDX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int CFG_IDX_W        = 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_TOL = 1'b0,
    CFG_COL_TOL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    start_mesh;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic signed [POS_W-1:0] vertex_z;
    logic [COL_W-1:0]        color_red;
    logic [COL_W-1:0]        color_green;
    logic [COL_W-1:0]        color_blue;
    logic [COL_W-1:0]        color_alpha;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             is_new;
    logic             overflow;
    logic [CNT_W-1:0] unique_count;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [COL_W-1:0]        red;
    logic [COL_W-1:0]        green;
    logic [COL_W-1:0]        blue;
    logic [COL_W-1:0]        alpha;
  } vertex_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic issue;
    logic finish;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic issue_avail;
    logic rd_pending;
    logic match;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/vdi_if.sv =====
interface vdi_in_if;
  import vdi_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdi_out_if;
  import vdi_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/vdi_ctrl.sv =====
module vdi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  vdi_pkg::dp_stat_t stat,
  output vdi_pkg::ctl_cmd_t cmd
);
  import vdi_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       scan_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    scan_done = stat.match || (!stat.issue_avail && !stat.rd_pending);
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue  = stat.issue_avail && !stat.match;
        cmd.finish = scan_done;
        if (scan_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/vdi_dp.sv =====
module vdi_dp #(
  parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vdi_pkg::ctl_cmd_t                  cmd,
  output vdi_pkg::dp_stat_t                  stat,
  input  vdi_pkg::in_item_t                  in_data,
  input  logic                               cfg_we,
  input  logic [vdi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vdi_pkg::TOL_W-1:0]          cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vdi_pkg::out_item_t                 out_data
);
  import vdi_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  vertex_t          mem [MAX_VERTICES];

  logic [TOL_W-1:0] pos_tol_r;
  logic [TOL_W-1:0] col_tol_r;
  vertex_t          item_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    issue_cnt_r;
  vertex_t          rd_data_r;
  logic [AW-1:0]    rd_idx_r;
  logic             rd_valid_r;
  logic [AW-1:0]    res_idx_r;
  logic             res_new_r;
  logic             res_ovf_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             match;
  logic             room;
  logic             wr_en;
  logic [IDX_W+AW-1:0] idx_ext;
  logic [CNT_W+CW-1:0] cnt_ext;

  function automatic logic pos_close(input logic signed [POS_W-1:0] a,
                                     input logic signed [POS_W-1:0] b,
                                     input logic [TOL_W-1:0]        tol);
    logic signed [POS_W:0] d_ab;
    logic signed [POS_W:0] d_ba;
    logic [POS_W:0]        mag;
    begin
      d_ab = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
      d_ba = $signed({b[POS_W-1], b}) - $signed({a[POS_W-1], a});
      mag  = d_ab[POS_W] ? d_ba : d_ab;
      return mag < {{(POS_W+1-TOL_W){1'b0}}, tol};
    end
  endfunction

  function automatic logic col_close(input logic [COL_W-1:0] a,
                                     input logic [COL_W-1:0] b,
                                     input logic [TOL_W-1:0] tol);
    logic [COL_W-1:0] mag;
    begin
      mag = (a > b) ? (a - b) : (b - a);
      return mag < tol;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tol_r <= TOL_RESET;
      col_tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POS_TOL: pos_tol_r <= cfg_data;
        CFG_COL_TOL: col_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r.x     <= in_data.vertex_x;
      item_r.y     <= in_data.vertex_y;
      item_r.z     <= in_data.vertex_z;
      item_r.red   <= in_data.color_red;
      item_r.green <= in_data.color_green;
      item_r.blue  <= in_data.color_blue;
      item_r.alpha <= in_data.color_alpha;
    end
  end

  assign room  = count_r < MAX_CNT;
  assign wr_en = cmd.finish && !match && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load_item && in_data.start_mesh) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      issue_cnt_r <= '0;
    end else if (cmd.issue) begin
      issue_cnt_r <= issue_cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[issue_cnt_r[AW-1:0]];
      rd_idx_r  <= issue_cnt_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  assign match = rd_valid_r &&
                 pos_close(item_r.x, rd_data_r.x, pos_tol_r) &&
                 pos_close(item_r.y, rd_data_r.y, pos_tol_r) &&
                 pos_close(item_r.z, rd_data_r.z, pos_tol_r) &&
                 col_close(item_r.red,   rd_data_r.red,   col_tol_r) &&
                 col_close(item_r.green, rd_data_r.green, col_tol_r) &&
                 col_close(item_r.blue,  rd_data_r.blue,  col_tol_r) &&
                 col_close(item_r.alpha, rd_data_r.alpha, col_tol_r);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority if (match) begin
        res_idx_r <= rd_idx_r;
        res_new_r <= 1'b0;
        res_ovf_r <= 1'b0;
      end else if (room) begin
        res_idx_r <= count_r[AW-1:0];
        res_new_r <= 1'b1;
        res_ovf_r <= 1'b0;
      end else begin
        res_idx_r <= '0;
        res_new_r <= 1'b0;
        res_ovf_r <= 1'b1;
      end
    end
  end

  assign idx_ext = {{IDX_W{1'b0}}, res_idx_r};
  assign cnt_ext = {{CNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.vertex_index <= idx_ext[IDX_W-1:0];
      out_data_r.is_new       <= res_new_r;
      out_data_r.overflow     <= res_ovf_r;
      out_data_r.unique_count <= cnt_ext[CNT_W-1:0];
    end
  end

  assign stat.issue_avail = issue_cnt_r < count_r;
  assign stat.rd_pending  = rd_valid_r;
  assign stat.match       = match;
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/vertex_dedup_indexer.sv =====
// Channel   Dir  Payload                                            Handshake
// in_chan   in   start_mesh, vertex_x/y/z, color_red/green/blue/alpha valid/ready
// out_chan  out  vertex_index, is_new, overflow, unique_count       valid/ready
// cfg       in   cfg_index, cfg_data (tolerances)                   cfg_we
//
// One item at a time. An item is scanned against the stored entries until the
// first match or the end of the table: the table scan reads one entry per cycle
// from the vertex memory into the read register, the entry is compared there,
// and the outcome passes through the result register into the output register.
// rst_n is synchronous; it empties the table and sets both tolerances to 1.
// A result waits in the output register while out_chan stalls; the next item
// is taken as soon as the previous result has moved into that register.
module vertex_dedup_indexer #(
  parameter int MAX_VERTICES = vdi_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  vdi_in_if.sink                        in_chan,
  vdi_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [vdi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vdi_pkg::TOL_W-1:0]     cfg_data
);
  import vdi_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  vdi_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

  assign in_chan.ready = cmd.in_ready;

`ifndef NO_ASSERTIONS
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> stat.issue_avail)
    else $error("read issued past the stored entries");

  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> !stat.rd_pending && !cmd.in_ready)
    else $error("stale read in flight at the start of a scan");

  a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.data.overflow |->
      !out_chan.data.is_new && (out_chan.data.vertex_index == '0))
    else $error("overflow result carries an index or new flag");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten while holding an item");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vdi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HISTORY_DEPTH  = 32;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TOL_W-1:0]     cfg_data;

  vdi_in_if  in_if ();
  vdi_out_if out_if ();

  vertex_dedup_indexer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // welding predictor state
  vertex_t          weld_store [MAX_VERTICES_DEF];
  int               stored_count = 0;
  logic [TOL_W-1:0] pos_tol = TOL_RESET;
  logic [TOL_W-1:0] col_tol = TOL_RESET;

  out_item_t expected_welds[$];
  vertex_t   recent[$];
  int        error_count = 0;
  int        burst_left = 0;
  int        ready_run = 0;
  int        ready_hold = 0;
  int        idle_cycles = 0;

  function automatic bit pos_near(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(pos_tol);
  endfunction

  function automatic bit col_near(logic [COL_W-1:0] a, logic [COL_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d < int'(col_tol);
  endfunction

  function automatic out_item_t weld_vertex(in_item_t it);
    out_item_t r;
    int        hit;
    hit = -1;
    if (it.start_mesh) stored_count = 0;
    for (int i = 0; i < stored_count && hit < 0; i++) begin
      if (pos_near(it.vertex_x, weld_store[i].x) && pos_near(it.vertex_y, weld_store[i].y) &&
          pos_near(it.vertex_z, weld_store[i].z) && col_near(it.color_red, weld_store[i].red) &&
          col_near(it.color_green, weld_store[i].green) &&
          col_near(it.color_blue, weld_store[i].blue) &&
          col_near(it.color_alpha, weld_store[i].alpha)) begin
        hit = i;
      end
    end
    r = '0;
    if (hit >= 0) begin
      r.vertex_index = IDX_W'(hit);
    end else if (stored_count < MAX_VERTICES_DEF) begin
      weld_store[stored_count] = '{it.vertex_x, it.vertex_y, it.vertex_z, it.color_red,
                                   it.color_green, it.color_blue, it.color_alpha};
      r.vertex_index = IDX_W'(stored_count);
      r.is_new = 1'b1;
      stored_count++;
    end else begin
      r.overflow = 1'b1;
    end
    r.unique_count = CNT_W'(stored_count);
    return r;
  endfunction

  function automatic in_item_t make_item(logic start, int x, int y, int z,
                                         int r, int g, int b, int a);
    in_item_t it;
    it.start_mesh  = start;
    it.vertex_x    = POS_W'(x);
    it.vertex_y    = POS_W'(y);
    it.vertex_z    = POS_W'(z);
    it.color_red   = COL_W'(r);
    it.color_green = COL_W'(g);
    it.color_blue  = COL_W'(b);
    it.color_alpha = COL_W'(a);
    return it;
  endfunction

  function automatic in_item_t to_item(logic start, vertex_t v);
    return make_item(start, int'(v.x), int'(v.y), int'(v.z),
                     int'(v.red), int'(v.green), int'(v.blue), int'(v.alpha));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(POS_W-1){1'b0}}};
      1: return {1'b0, {(POS_W-1){1'b1}}};
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COL_W'($urandom);
    endcase
  endfunction

  function automatic vertex_t fresh_vertex();
    vertex_t v;
    v.x     = pick_pos();
    v.y     = pick_pos();
    v.z     = pick_pos();
    v.red   = pick_col();
    v.green = pick_col();
    v.blue  = pick_col();
    v.alpha = pick_col();
    return v;
  endfunction

  // move a field by a random amount around the tolerance boundary
  function automatic int jitter(int tol);
    int span;
    span = 2 * tol + 2;
    if ($urandom_range(0, 1) == 0) return 0;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic in_item_t random_item();
    vertex_t v;
    if (recent.size() == 0 || $urandom_range(0, 7) == 0) begin
      v = fresh_vertex();
    end else begin
      v       = recent[$urandom_range(0, recent.size() - 1)];
      v.x     = POS_W'(int'(v.x) + jitter(int'(pos_tol)));
      v.y     = POS_W'(int'(v.y) + jitter(int'(pos_tol)));
      v.z     = POS_W'(int'(v.z) + jitter(int'(pos_tol)));
      v.red   = COL_W'(int'(v.red) + jitter(int'(col_tol)));
      v.green = COL_W'(int'(v.green) + jitter(int'(col_tol)));
      v.blue  = COL_W'(int'(v.blue) + jitter(int'(col_tol)));
      v.alpha = COL_W'(int'(v.alpha) + jitter(int'(col_tol)));
    end
    recent.push_back(v);
    if (recent.size() > HISTORY_DEPTH) void'(recent.pop_front());
    return to_item($urandom_range(0, 24) == 0, v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_vertex(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    expected_welds.push_back(weld_vertex(it));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_welds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tolerances(logic [TOL_W-1:0] p, logic [TOL_W-1:0] c);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POS_TOL;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= CFG_COL_TOL;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    pos_tol = p;
    col_tol = c;
  endtask

  // reset tolerances: exact matches only, field extremes
  task automatic test_exact_match();
    send_vertex(make_item(1'b1, 0, 0, 0, 0, 0, 0, 0));
    send_vertex(make_item(1'b0, 0, 0, 0, 0, 0, 0, 0));
    send_vertex(make_item(1'b0, 8388607, -8388608, 0, 65535, 65535, 65535, 65535));
    send_vertex(make_item(1'b0, -8388608, 8388607, -1, 0, 65535, 0, 65535));
    send_vertex(make_item(1'b0, 8388607, -8388608, 0, 65535, 65535, 65535, 65535));
    send_vertex(make_item(1'b0, 8388607, -8388608, 0, 65535, 65535, 65534, 65535));
    send_vertex(make_item(1'b1, 8388607, -8388608, 0, 65535, 65535, 65535, 65535));
  endtask

  // differences just below and at the tolerance, first match wins
  task automatic test_tolerance_edges();
    set_tolerances(16, 16);
    send_vertex(make_item(1'b1, 1000, -2000, 300, 100, 200, 300, 400));
    send_vertex(make_item(1'b0, 1015, -2000, 300, 100, 200, 300, 400));
    send_vertex(make_item(1'b0, 1000, -2015, 300, 100, 200, 300, 400));
    send_vertex(make_item(1'b0, 1000, -2000, 300, 100, 200, 300, 415));
    send_vertex(make_item(1'b0, 1000, -2000, 316, 100, 200, 300, 400));
    send_vertex(make_item(1'b0, 1000, -2000, 300, 84, 200, 300, 400));
    send_vertex(make_item(1'b0, 1000, -2000, 308, 100, 200, 300, 400));
  endtask

  // widest tolerances; opposite ends of the signed range never weld
  task automatic test_signed_range();
    set_tolerances(65535, 65535);
    send_vertex(make_item(1'b1, -8388608, 0, 0, 0, 0, 0, 0));
    send_vertex(make_item(1'b0, 8388607, 0, 0, 65535, 0, 0, 0));
    send_vertex(make_item(1'b0, -8388608 + 65534, 0, 0, 65534, 0, 0, 0));
    send_vertex(make_item(1'b0, -8388608, 65535, 0, 0, 0, 0, 0));
  endtask

  // zero tolerance appends everything until the table is full; then overflow and matches at tolerance 1
  task automatic test_table_full();
    vertex_t last_v;
    vertex_t early_v;
    set_tolerances(0, 0);
    for (int i = 0; i < MAX_VERTICES_DEF; i++) send_vertex(to_item(i == 0, fresh_vertex()));
    send_vertex(to_item(1'b0, fresh_vertex()));
    last_v  = weld_store[MAX_VERTICES_DEF-1];
    early_v = weld_store[5];
    send_vertex(to_item(1'b0, last_v));
    set_tolerances(1, 1);
    send_vertex(to_item(1'b0, last_v));
    send_vertex(to_item(1'b0, early_v));
    send_vertex(make_item(1'b0, 12345, -54321, 777, 1, 2, 3, 4));
    send_vertex(to_item(1'b1, early_v));
  endtask

  task automatic test_random_mix(logic [TOL_W-1:0] p, logic [TOL_W-1:0] c, int n);
    set_tolerances(p, c);
    recent.delete();
    for (int i = 0; i < n; i++) send_vertex(random_item());
  endtask

  always @(posedge clk) begin
    if (ready_run > 0) begin
      out_if.ready <= 1'b1;
      ready_run--;
    end else if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_if.ready <= 1'b0;
      ready_run  = $urandom_range(0, 40);
      ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_welds.size() == 0) begin
        report_mismatch($sformatf("unexpected result, index %0d", out_if.data.vertex_index));
      end else begin
        want = expected_welds.pop_front();
        if (out_if.data.vertex_index !== want.vertex_index)
          report_mismatch($sformatf("vertex_index got %0d want %0d",
                                    out_if.data.vertex_index, want.vertex_index));
        if (out_if.data.is_new !== want.is_new)
          report_mismatch($sformatf("is_new got %0b want %0b",
                                    out_if.data.is_new, want.is_new));
        if (out_if.data.overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %0b want %0b",
                                    out_if.data.overflow, want.overflow));
        if (out_if.data.unique_count !== want.unique_count)
          report_mismatch($sformatf("unique_count got %0d want %0d",
                                    out_if.data.unique_count, want.unique_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_POS_TOL;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_exact_match();
    test_tolerance_edges();
    test_signed_range();
    test_table_full();
    test_random_mix(1, 1, 92);
    test_random_mix(65535, 65535, 92);
    test_random_mix(256, 4096, 92);
    test_random_mix(1, 65535, 92);
    test_random_mix(65535, 1, 92);
    test_random_mix(TOL_W'($urandom_range(1, 65535)), TOL_W'($urandom_range(1, 65535)), 92);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
